@@ hw/rtl/crcfp_pkg.sv @@
// shared types, constants and crc helpers for the crc16 frame receive parser
// no dependencies
package crcfp_pkg;

  localparam int DefChannels = 4;
  localparam int DefMaxData  = 64;

  localparam logic [7:0]  HdrFirst  = 8'hFE;
  localparam logic [7:0]  HdrSecond = 8'hEF;

  localparam logic [15:0] TimeoutReset = 16'd100;
  localparam logic [15:0] PolyReset    = 16'h8005;
  localparam logic [15:0] InitReset    = 16'hFFFF;
  localparam logic        ReflectReset = 1'b1;
  localparam logic [15:0] XoroutReset  = 16'h0000;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT = 3'd0,
    CFG_POLY    = 3'd1,
    CFG_INIT    = 3'd2,
    CFG_REFLECT = 3'd3,
    CFG_XOROUT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    PH_HUNT  = 5'b00001,
    PH_TYPE  = 5'b00010,
    PH_LEN   = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [1:0] channel;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_channel;
    logic [7:0] msg_type;
    logic [6:0] msg_length;
    logic       has_data;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic emit_start;
    logic rd_en;
    logic load_out;
    logic k_inc;
  } ctl_cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic out_free;
    logic last;
  } dp_sts_t;

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly, input logic reflect);
    logic [15:0] c;
    logic [15:0] rp;
    c  = crc;
    rp = rev16(poly);
    if (reflect) begin
      c = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ rp) : (c >> 1);
      end
    end else begin
      c = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ poly) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/crcfp_stream_if.sv @@
// valid/ready stream interface carrying one item per handshake
// payload type is set by the instantiating level
interface crcfp_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/crc16_frame_receive_parser_top.sv @@
// top level of the crc16 frame receive parser: controller plus datapath
// depends on crcfp_pkg, crcfp_stream_if, crcfp_ctl, crcfp_dp
//
// channel  dir  item                                   handshake
// rx_i     in   action, channel, rx_byte               valid/ready
// res_o    out  out_channel .. last, one per data byte valid/ready
// cfg      in   cfg_idx_i, cfg_wdata_i                 cfg_we_i, no wait
//
// a byte or tick is taken every cycle while no frame run is in progress
// a passing frame of n data bytes gives n results (one for an empty frame),
// each from one payload memory read then one result register load
// input stays held off for the whole run; the last result may still wait at the
// output while new items are taken
// reset clears parse state and config at once; payload memory is not cleared
module crc16_frame_receive_parser_top #(
  parameter int CHANNELS = crcfp_pkg::DefChannels,
  parameter int MAX_DATA = crcfp_pkg::DefMaxData
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  crcfp_stream_if.sink                   rx_i,
  crcfp_stream_if.source                 res_o,
  input  logic                           cfg_we_i,
  input  logic [crcfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [crcfp_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import crcfp_pkg::*;

  ctl_cmd_t  cmd;
  dp_sts_t   sts;
  logic      rx_ready;
  logic      res_valid;
  out_item_t res_data;

  crcfp_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crcfp_dp #(
    .CHANNELS (CHANNELS),
    .MAX_DATA (MAX_DATA)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_data_i   (rx_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .res_ready_i (res_o.ready)
  );

  assign rx_i.ready  = rx_ready;
  assign res_o.valid = res_valid;
  assign res_o.data  = res_data;

endmodule

@@ hw/rtl/crcfp_ctl.sv @@
// controller: accepts items and sequences the result run of a passing frame
// depends on crcfp_pkg
module crcfp_ctl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  output logic                rx_ready_o,
  input  crcfp_pkg::dp_sts_t  sts_i,
  output crcfp_pkg::ctl_cmd_t cmd_o
);
  import crcfp_pkg::*;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_READ = 3'b010,
    CS_SHOW = 3'b100
  } ctl_state_e;

  ctl_state_e state_q, state_d;

  always_comb begin
    rx_ready_o       = (state_q == CS_IDLE);
    cmd_o.accept     = rx_valid_i && rx_ready_o;
    cmd_o.emit_start = cmd_o.accept && sts_i.frame_ok;
    cmd_o.rd_en      = (state_q == CS_READ);
    cmd_o.load_out   = (state_q == CS_SHOW) && sts_i.out_free;
    cmd_o.k_inc      = cmd_o.load_out && !sts_i.last;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (cmd_o.emit_start) state_d = CS_READ;
      end
      CS_READ: begin
        state_d = CS_SHOW;
      end
      CS_SHOW: begin
        if (sts_i.out_free) state_d = sts_i.last ? CS_IDLE : CS_READ;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/crcfp_dp.sv @@
// datapath: config registers, per-channel parse state, crc, payload memory,
// result register; depends on crcfp_pkg
module crcfp_dp #(
  parameter int CHANNELS = crcfp_pkg::DefChannels,
  parameter int MAX_DATA = crcfp_pkg::DefMaxData
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [crcfp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [crcfp_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  crcfp_pkg::in_item_t               rx_data_i,
  input  crcfp_pkg::ctl_cmd_t               cmd_i,
  output crcfp_pkg::dp_sts_t                sts_o,
  output logic                              res_valid_o,
  output crcfp_pkg::out_item_t              res_data_o,
  input  logic                              res_ready_i
);
  import crcfp_pkg::*;

  localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KW    = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int Depth = CHANNELS * MAX_DATA;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AW-1:0] MaxDataA = AW'(MAX_DATA);
  localparam logic [8:0]    MaxData9 = 9'(MAX_DATA);

  // configuration
  logic [15:0] timeout_q, poly_q, init_q, xorout_q;
  logic        reflect_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      poly_q    <= PolyReset;
      init_q    <= InitReset;
      reflect_q <= ReflectReset;
      xorout_q  <= XoroutReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        CFG_POLY:    poly_q    <= cfg_wdata_i;
        CFG_INIT:    init_q    <= cfg_wdata_i;
        CFG_REFLECT: reflect_q <= cfg_wdata_i[0];
        CFG_XOROUT:  xorout_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-channel parse state
  phase_e      phase_q   [CHANNELS];
  logic        matched_q [CHANNELS];
  logic [7:0]  dcount_q  [CHANNELS];
  logic        ccount_q  [CHANNELS];
  logic [7:0]  chigh_q   [CHANNELS];
  logic [7:0]  ftype_q   [CHANNELS];
  logic [7:0]  flen_q    [CHANNELS];
  logic [15:0] crc_q     [CHANNELS];
  logic [15:0] idle_q;

  logic [ChW-1:0] ch_idx;
  logic           is_byte, chan_ok, upd;
  phase_e         ph_cur, phase_d;
  logic           matched_cur, matched_d;
  logic [7:0]     dcount_d, chigh_d, ftype_d, flen_d;
  logic           ccount_d;
  logic [15:0]    crc_d, crc_base;
  logic [7:0]     b;
  logic [8:0]     dcount_inc;
  logic           mem_we;
  logic [AW-1:0]  wr_addr;
  logic           frame_ok;

  always_comb begin
    ch_idx      = ChW'(rx_data_i.channel);
    b           = rx_data_i.rx_byte;
    is_byte     = !rx_data_i.action;
    chan_ok     = (32'(rx_data_i.channel) < CHANNELS);
    upd         = cmd_i.accept && is_byte && chan_ok;
    ph_cur      = phase_q[ch_idx];
    matched_cur = matched_q[ch_idx];
    if (idle_q > timeout_q) begin
      ph_cur      = PH_HUNT;
      matched_cur = 1'b0;
    end
    phase_d    = ph_cur;
    matched_d  = matched_cur;
    dcount_d   = dcount_q[ch_idx];
    ccount_d   = ccount_q[ch_idx];
    chigh_d    = chigh_q[ch_idx];
    ftype_d    = ftype_q[ch_idx];
    flen_d     = flen_q[ch_idx];
    crc_base   = crc_q[ch_idx];
    dcount_inc = 9'(dcount_q[ch_idx]) + 9'd1;
    mem_we     = 1'b0;
    frame_ok   = 1'b0;
    case (ph_cur)
      PH_TYPE: begin
        ftype_d  = b;
        crc_base = reflect_q ? rev16(init_q) : init_q;
        phase_d  = PH_LEN;
      end
      PH_LEN: begin
        flen_d   = b;
        dcount_d = 8'd0;
        ccount_d = 1'b0;
        phase_d  = (b == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        mem_we   = (9'(dcount_q[ch_idx]) < MaxData9);
        dcount_d = dcount_inc[7:0];
        if (dcount_inc >= 9'(flen_q[ch_idx])) begin
          ccount_d = 1'b0;
          phase_d  = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (!ccount_q[ch_idx]) begin
          chigh_d  = b;
          ccount_d = 1'b1;
        end else begin
          ccount_d  = 1'b0;
          phase_d   = PH_HUNT;
          matched_d = 1'b0;
          frame_ok  = ({chigh_q[ch_idx], b} == (crc_q[ch_idx] ^ xorout_q)) &&
                      (9'(flen_q[ch_idx]) <= MaxData9);
        end
      end
      default: begin
        phase_d = PH_HUNT;
        if (b == (matched_cur ? HdrSecond : HdrFirst)) begin
          if (matched_cur) begin
            matched_d = 1'b0;
            phase_d   = PH_TYPE;
          end else begin
            matched_d = 1'b1;
          end
        end else begin
          matched_d = 1'b0;
        end
      end
    endcase
    crc_d = crc_base;
    if (ph_cur == PH_TYPE || ph_cur == PH_LEN || ph_cur == PH_DATA) begin
      crc_d = crc_feed(crc_base, b, poly_q, reflect_q);
    end
    wr_addr = AW'(ch_idx) * MaxDataA + AW'(dcount_q[ch_idx]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_q[i]   <= PH_HUNT;
        matched_q[i] <= 1'b0;
        dcount_q[i]  <= 8'd0;
        ccount_q[i]  <= 1'b0;
        chigh_q[i]   <= 8'd0;
        ftype_q[i]   <= 8'd0;
        flen_q[i]    <= 8'd0;
        crc_q[i]     <= 16'd0;
      end
      idle_q <= 16'hFFFF;
    end else if (cmd_i.accept) begin
      if (!is_byte) begin
        if (idle_q != 16'hFFFF) idle_q <= idle_q + 16'd1;
      end else if (chan_ok) begin
        idle_q            <= 16'd0;
        phase_q[ch_idx]   <= phase_d;
        matched_q[ch_idx] <= matched_d;
        dcount_q[ch_idx]  <= dcount_d;
        ccount_q[ch_idx]  <= ccount_d;
        chigh_q[ch_idx]   <= chigh_d;
        ftype_q[ch_idx]   <= ftype_d;
        flen_q[ch_idx]    <= flen_d;
        crc_q[ch_idx]     <= crc_d;
      end
    end
  end

  // payload memory
  logic [7:0]    mem [Depth];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (upd && mem_we) mem[wr_addr] <= b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_data_q <= mem[rd_addr];
  end

  // frame run
  logic [1:0]    em_ch_q;
  logic [ChW-1:0] em_idx_q;
  logic [7:0]    em_type_q, em_len_q;
  logic [KW-1:0] k_q;
  logic          em_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.emit_start) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_start) begin
      em_ch_q   <= rx_data_i.channel;
      em_idx_q  <= ch_idx;
      em_type_q <= ftype_q[ch_idx];
      em_len_q  <= flen_q[ch_idx];
    end
  end

  assign rd_addr = AW'(em_idx_q) * MaxDataA + AW'(k_q);
  assign em_last = (em_len_q == 8'd0) || ((9'(k_q) + 9'd1) == 9'(em_len_q));

  // result register
  logic      res_valid_q;
  out_item_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q.out_channel <= em_ch_q;
      res_q.msg_type    <= em_type_q;
      res_q.msg_length  <= em_len_q[6:0];
      res_q.has_data    <= (em_len_q != 8'd0);
      res_q.data_byte   <= (em_len_q != 8'd0) ? rd_data_q : 8'd0;
      res_q.byte_index  <= (em_len_q != 8'd0) ? 6'(k_q) : 6'd0;
      res_q.last        <= em_last;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign res_data_o     = res_q;
  assign sts_o.frame_ok = upd && frame_ok;
  assign sts_o.out_free = !res_valid_q || res_ready_i;
  assign sts_o.last     = em_last;

endmodule

@@ dv/crc16_frame_receive_parser_top_tb.sv @@
// self-checking testbench for crc16_frame_receive_parser_top: byte and tick stimulus,
// an in-bench frame parser that predicts every result, random stalls on both sides
// depends on crcfp_pkg, crcfp_stream_if and the rtl of the block
`timescale 1ns / 1ps

module crc16_frame_receive_parser_top_tb;
  import crcfp_pkg::*;

  localparam int Chans   = DefChannels;
  localparam int MaxData = DefMaxData;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  crcfp_stream_if #(.item_t(in_item_t))  rx_if ();
  crcfp_stream_if #(.item_t(out_item_t)) res_if ();

  crc16_frame_receive_parser_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // register copies
  logic [15:0] cfg_timeout, cfg_poly, cfg_init, cfg_xorout;
  logic        cfg_reflect;

  // per-channel parse state
  phase_e      ch_phase   [Chans];
  logic        hdr_seen   [Chans];
  logic [7:0]  ch_count   [Chans];
  logic        chk_second [Chans];
  logic [7:0]  chk_hi     [Chans];
  logic [7:0]  ch_type    [Chans];
  logic [7:0]  ch_len     [Chans];
  logic [15:0] ch_crc     [Chans];
  logic [7:0]  ch_payload [Chans][MaxData];
  logic [15:0] idle_cnt;

  in_item_t  rx_pend_q[$];
  in_item_t  lane_q[Chans][$];
  out_item_t frame_out_q[$];

  int  mismatches = 0;
  int  pushed_cnt = 0;
  int  taken_cnt  = 0;
  int  queued     = 0;
  int  tx_gap     = 0;
  int  rx_gap     = 0;
  bit  quiet      = 0;
  logic rx_took   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3600000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] mirror16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) r[15-i] = v[i];
    return r;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] acc_in, input logic [7:0] b);
    logic [15:0] acc;
    logic [15:0] rpoly;
    acc   = acc_in;
    rpoly = mirror16(cfg_poly);
    if (cfg_reflect) begin
      acc[7:0] = acc[7:0] ^ b;
      for (int i = 0; i < 8; i++) acc = acc[0] ? ((acc >> 1) ^ rpoly) : (acc >> 1);
    end else begin
      acc[15:8] = acc[15:8] ^ b;
      for (int i = 0; i < 8; i++) acc = acc[15] ? ((acc << 1) ^ cfg_poly) : (acc << 1);
    end
    return acc;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic reset_model();
    cfg_timeout = TimeoutReset;
    cfg_poly    = PolyReset;
    cfg_init    = InitReset;
    cfg_reflect = ReflectReset;
    cfg_xorout  = XoroutReset;
    for (int c = 0; c < Chans; c++) begin
      ch_phase[c]   = PH_HUNT;
      hdr_seen[c]   = 1'b0;
      ch_count[c]   = '0;
      chk_second[c] = 1'b0;
      chk_hi[c]     = '0;
      ch_type[c]    = '0;
      ch_len[c]     = '0;
      ch_crc[c]     = '0;
    end
    idle_cnt = 16'hFFFF;
  endtask

  task automatic emit_frame(input int ch);
    out_item_t o;
    o.out_channel = 2'(ch);
    o.msg_type    = ch_type[ch];
    if (ch_len[ch] == 0) begin
      o.msg_length = '0;
      o.has_data   = 1'b0;
      o.data_byte  = '0;
      o.byte_index = '0;
      o.last       = 1'b1;
      frame_out_q.push_back(o);
    end else begin
      for (int k = 0; k < ch_len[ch]; k++) begin
        o.msg_length = 7'(ch_len[ch]);
        o.has_data   = 1'b1;
        o.data_byte  = ch_payload[ch][k];
        o.byte_index = 6'(k);
        o.last       = (k + 1 == ch_len[ch]);
        frame_out_q.push_back(o);
      end
    end
  endtask

  task automatic parse_item(input in_item_t it);
    int         ch;
    logic [7:0] b;
    ch = it.channel;
    b  = it.rx_byte;
    if (it.action) begin
      if (idle_cnt != 16'hFFFF) idle_cnt++;
    end else begin
      if (idle_cnt > cfg_timeout) begin
        ch_phase[ch] = PH_HUNT;
        hdr_seen[ch] = 1'b0;
      end
      idle_cnt = '0;
      case (ch_phase[ch])
        PH_TYPE: begin
          ch_type[ch]  = b;
          ch_crc[ch]   = crc_byte(cfg_reflect ? mirror16(cfg_init) : cfg_init, b);
          ch_phase[ch] = PH_LEN;
        end
        PH_LEN: begin
          ch_len[ch]     = b;
          ch_crc[ch]     = crc_byte(ch_crc[ch], b);
          ch_count[ch]   = '0;
          chk_second[ch] = 1'b0;
          ch_phase[ch]   = (b == 0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          if (ch_count[ch] < MaxData) ch_payload[ch][ch_count[ch]] = b;
          ch_crc[ch]   = crc_byte(ch_crc[ch], b);
          ch_count[ch] = ch_count[ch] + 8'd1;
          if (ch_count[ch] >= ch_len[ch]) begin
            chk_second[ch] = 1'b0;
            ch_phase[ch]   = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (!chk_second[ch]) begin
            chk_hi[ch]     = b;
            chk_second[ch] = 1'b1;
          end else begin
            chk_second[ch] = 1'b0;
            ch_phase[ch]   = PH_HUNT;
            hdr_seen[ch]   = 1'b0;
            if ({chk_hi[ch], b} == (ch_crc[ch] ^ cfg_xorout) && ch_len[ch] <= MaxData)
              emit_frame(ch);
          end
        end
        default: begin
          ch_phase[ch] = PH_HUNT;
          if (b == (hdr_seen[ch] ? HdrSecond : HdrFirst)) begin
            if (hdr_seen[ch]) begin
              hdr_seen[ch] = 1'b0;
              ch_phase[ch] = PH_TYPE;
            end else begin
              hdr_seen[ch] = 1'b1;
            end
          end else begin
            hdr_seen[ch] = 1'b0;
          end
        end
      endcase
    end
  endtask

  // result check then prediction, both on accepted items
  always @(posedge clk_i) begin
    out_item_t want;
    rx_took <= rx_if.valid && rx_if.ready;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (frame_out_q.size() == 0) begin
          log_mismatch("result with nothing expected");
        end else begin
          want = frame_out_q.pop_front();
          check_field("out_channel", res_if.data.out_channel, want.out_channel);
          check_field("msg_type", res_if.data.msg_type, want.msg_type);
          check_field("msg_length", res_if.data.msg_length, want.msg_length);
          check_field("has_data", res_if.data.has_data, want.has_data);
          check_field("data_byte", res_if.data.data_byte, want.data_byte);
          check_field("byte_index", res_if.data.byte_index, want.byte_index);
          check_field("last", res_if.data.last, want.last);
        end
      end
      if (rx_if.valid && rx_if.ready) begin
        parse_item(rx_if.data);
        taken_cnt++;
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && !(rx_if.valid && !rx_took)) begin
      if (tx_gap > 0) begin
        tx_gap      <= tx_gap - 1;
        rx_if.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        tx_gap      <= $urandom_range(0, 10);
        rx_if.valid <= 1'b0;
      end else if (rx_pend_q.size() > 0) begin
        rx_if.data  <= rx_pend_q.pop_front();
        rx_if.valid <= 1'b1;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // result sink with stall bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_gap > 0) begin
        rx_gap       <= rx_gap - 1;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_gap       <= $urandom_range(0, 10);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input in_item_t it);
    rx_pend_q.push_back(it);
    pushed_cnt++;
    queued++;
  endtask

  task automatic push_tick();
    in_item_t it;
    it.action  = 1'b1;
    it.channel = 2'($urandom);
    it.rx_byte = 8'($urandom);
    push_item(it);
  endtask

  task automatic lane_byte(input int ch, input logic [7:0] b);
    in_item_t it;
    it.action  = 1'b0;
    it.channel = 2'(ch);
    it.rx_byte = b;
    lane_q[ch].push_back(it);
  endtask

  function automatic int lanes_left();
    int n;
    n = 0;
    for (int c = 0; c < Chans; c++) n += lane_q[c].size();
    return n;
  endfunction

  // interleave channel streams, with bursts of ticks in between
  task automatic merge_lanes(input int tick_pct, input int tick_max);
    int pick;
    while (lanes_left() > 0) begin
      pick = $urandom_range(0, Chans - 1);
      if (lane_q[pick].size() > 0) begin
        if ($urandom_range(0, 99) < tick_pct) repeat ($urandom_range(1, tick_max)) push_tick();
        push_item(lane_q[pick].pop_front());
      end
    end
  endtask

  // typ and fill below zero mean random
  task automatic add_frame(input int ch, input int len, input int typ, input int fill,
                           input bit corrupt);
    logic [7:0]  t;
    logic [7:0]  d;
    logic [15:0] acc;
    t = (typ < 0) ? 8'($urandom) : 8'(typ);
    lane_byte(ch, HdrFirst);
    lane_byte(ch, HdrSecond);
    lane_byte(ch, t);
    lane_byte(ch, 8'(len));
    acc = crc_byte(cfg_reflect ? mirror16(cfg_init) : cfg_init, t);
    acc = crc_byte(acc, 8'(len));
    for (int k = 0; k < len; k++) begin
      d = (fill < 0) ? 8'($urandom) : 8'(fill);
      lane_byte(ch, d);
      acc = crc_byte(acc, d);
    end
    acc = acc ^ cfg_xorout;
    if (corrupt) acc = acc ^ (16'h1 << $urandom_range(0, 15));
    lane_byte(ch, acc[15:8]);
    lane_byte(ch, acc[7:0]);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 6);
    if (r < 90) return $urandom_range(7, 20);
    if (r < 97) return $urandom_range(21, MaxData);
    return $urandom_range(MaxData + 1, MaxData + 8);
  endfunction

  task automatic random_phase(input int goal, input int tick_pct, input int tick_max,
                              input int forced_len);
    int         ch;
    int         r;
    logic [7:0] b;
    queued = 0;
    if (forced_len >= 0) add_frame($urandom_range(0, Chans - 1), forced_len, -1, -1, 0);
    while (queued < goal) begin
      repeat ($urandom_range(1, 3)) begin
        ch = $urandom_range(0, Chans - 1);
        r  = $urandom_range(0, 99);
        if (r < 72) begin
          add_frame(ch, pick_len(), -1, -1, 0);
        end else if (r < 84) begin
          add_frame(ch, pick_len(), -1, -1, 1);
        end else if (r < 92) begin
          // header start with a bad second byte
          b = 8'($urandom);
          if (b == HdrSecond) b = 8'h00;
          lane_byte(ch, HdrFirst);
          lane_byte(ch, b);
        end else begin
          repeat ($urandom_range(1, 3)) lane_byte(ch, 8'($urandom));
        end
      end
      merge_lanes(tick_pct, tick_max);
    end
  endtask

  // hold the sender until every item is taken and every result is out
  task automatic drain();
    while (taken_cnt != pushed_cnt || frame_out_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    case (idx)
      CFG_TIMEOUT: cfg_timeout = val;
      CFG_POLY:    cfg_poly    = val;
      CFG_INIT:    cfg_init    = val;
      CFG_REFLECT: cfg_reflect = val[0];
      CFG_XOROUT:  cfg_xorout  = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] tmo, input logic [15:0] poly,
                            input logic [15:0] init, input logic refl,
                            input logic [15:0] xorout);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_POLY, poly);
    write_reg(CFG_INIT, init);
    write_reg(CFG_REFLECT, {15'd0, refl});
    write_reg(CFG_XOROUT, xorout);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    rx_if.valid  = 1'b0;
    rx_if.data   = '0;
    res_if.ready = 1'b0;
    reset_model();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // saturated idle count, header recheck, empty frame, extreme bytes, bad check
    push_tick();
    lane_byte(0, HdrFirst);
    lane_byte(0, HdrFirst);
    lane_byte(0, HdrSecond);
    add_frame(0, 0, 8'h00, -1, 0);
    add_frame(3, 1, 8'hFF, 8'hFF, 0);
    add_frame(1, 1, 8'h5A, 8'h00, 1);
    merge_lanes(0, 1);
    drain();

    set_config(16'd100, 16'h1021, 16'hFFFF, 1'b0, 16'h0000);
    random_phase(50, 10, 4, MaxData + 1);
    drain();

    set_config(16'd3, 16'h8005, 16'h0000, 1'b1, 16'hFFFF);
    random_phase(50, 15, 6, -1);
    drain();

    set_config(16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF);
    random_phase(50, 4, 2, MaxData);
    drain();

    set_config(16'hFFFF, 16'h0000, 16'h0000, 1'b1, 16'h0000);
    random_phase(50, 25, 10, -1);
    drain();

    quiet = 1;
    set_config(16'($urandom_range(0, 8)), 16'($urandom), 16'($urandom), 1'($urandom),
               16'($urandom));
    random_phase(50, 10, 5, -1);
    drain();
    repeat (20) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
